// ===== sv/frame_delta_run_encoder_defines.svh =====
// Assertion helpers for the frame delta run encoder.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef FRAME_DELTA_RUN_ENCODER_DEFINES_SVH
`define FRAME_DELTA_RUN_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define FDRE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FDRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fdre_pkg.sv =====
package fdre_pkg;

  // Reference store geometry
  localparam int unsigned MAX_FRAME_WORDS = 2097152;
  localparam int unsigned IDX_W           = $clog2(MAX_FRAME_WORDS);
  localparam int unsigned FW_W            = 22;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BYTES_W         = 24;

  localparam logic [FW_W-1:0] FRAME_WORDS_RST = FW_W'(2073600);
  localparam logic [FW_W-1:0] FRAME_WORDS_MAX = FW_W'(MAX_FRAME_WORDS);
  localparam logic [FW_W-1:0] FRAME_WORDS_MIN = FW_W'(1);

  // Byte accounting
  localparam logic [BYTES_W-1:0] RUN_HDR_BYTES = BYTES_W'(8);
  localparam logic [BYTES_W-1:0] WORD_BYTES    = BYTES_W'(4);

  // Records per input beat
  localparam int unsigned MAX_RECS  = 4;
  localparam int unsigned REC_CNT_W = $clog2(MAX_RECS + 1);
  localparam int unsigned REC_PTR_W = $clog2(MAX_RECS);

  // Input kinds
  localparam logic KIND_COMPARE = 1'b0;
  localparam logic KIND_PRIME   = 1'b1;

  typedef enum logic [1:0] {
    REC_START = 2'd0,
    REC_DATA  = 2'd1,
    REC_END   = 2'd2,
    REC_TOTAL = 2'd3
  } rec_type_e;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] pixel_word;
  } in_beat_t;

  typedef struct packed {
    rec_type_e         record_type;
    logic [WORD_W-1:0] record_value;
    logic              last_of_step;
  } out_beat_t;

  // Item waiting on its reference read
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [WORD_W-1:0] pixel_word;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } item_t;

  typedef struct packed {
    rec_type_e         rtype;
    logic [WORD_W-1:0] value;
  } rec_t;

  // All records caused by one item
  typedef struct packed {
    logic [REC_CNT_W-1:0]      n;
    rec_t [MAX_RECS-1:0]       recs;
  } rec_set_t;

endpackage

// ===== sv/fdre_ref_ram.sv =====
module fdre_ref_ram import fdre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] ref_mem [MAX_FRAME_WORDS];
  logic [WORD_W-1:0] rd_data_q;
  logic [WORD_W-1:0] fwd_data_q;
  logic              fwd_hit_q;

  // Single write port, single registered read port (read-first)
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ref_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= ref_mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Bypass: read and write to the same entry in one cycle returns the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_data_q;

endmodule

// ===== sv/fdre_run_ctrl.sv =====
module fdre_run_ctrl import fdre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             item_i,
  input  logic [WORD_W-1:0] ref_word_i,
  input  logic              advance_i,
  output rec_set_t          rec_set_o,
  output logic              wr_en_o
);

  logic               in_run_q, in_run_d;
  logic [BYTES_W-1:0] run_bytes_q, run_bytes_d;
  logic [BYTES_W-1:0] total_bytes_q, total_bytes_d;
  logic               changed;

  assign changed = (ref_word_i != item_i.pixel_word);

  // Record builder and run state update
  always_comb begin
    logic [REC_CNT_W-1:0] n;
    n             = '0;
    rec_set_o     = '0;
    in_run_d      = in_run_q;
    run_bytes_d   = run_bytes_q;
    total_bytes_d = total_bytes_q;
    if (item_i.kind == KIND_PRIME) begin
      // prime abandons any frame in progress
      in_run_d      = 1'b0;
      run_bytes_d   = '0;
      total_bytes_d = '0;
    end else begin
      if (changed) begin
        if (!in_run_q) begin
          rec_set_o.recs[0] = '{rtype: REC_START,
                                value: WORD_W'({item_i.idx, 2'b00})};
          n             = REC_CNT_W'(1);
          run_bytes_d   = '0;
          total_bytes_d = total_bytes_d + RUN_HDR_BYTES;
        end
        rec_set_o.recs[n[REC_PTR_W-1:0]] = '{rtype: REC_DATA, value: item_i.pixel_word};
        n             = n + REC_CNT_W'(1);
        run_bytes_d   = run_bytes_d + WORD_BYTES;
        total_bytes_d = total_bytes_d + WORD_BYTES;
        in_run_d      = 1'b1;
      end else if (in_run_q) begin
        rec_set_o.recs[0] = '{rtype: REC_END, value: WORD_W'(run_bytes_q)};
        n           = REC_CNT_W'(1);
        in_run_d    = 1'b0;
        run_bytes_d = '0;
      end
      // end of frame: close open run, then frame total
      if (item_i.last) begin
        if (in_run_d) begin
          rec_set_o.recs[n[REC_PTR_W-1:0]] = '{rtype: REC_END, value: WORD_W'(run_bytes_d)};
          n = n + REC_CNT_W'(1);
        end
        rec_set_o.recs[n[REC_PTR_W-1:0]] = '{rtype: REC_TOTAL, value: WORD_W'(total_bytes_d)};
        n             = n + REC_CNT_W'(1);
        in_run_d      = 1'b0;
        run_bytes_d   = '0;
        total_bytes_d = '0;
      end
    end
    rec_set_o.n = n;
  end

  // Reference update: primes always, compares only on change
  assign wr_en_o = advance_i && ((item_i.kind == KIND_PRIME) || changed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q      <= 1'b0;
      run_bytes_q   <= '0;
      total_bytes_q <= '0;
    end else if (advance_i) begin
      in_run_q      <= in_run_d;
      run_bytes_q   <= run_bytes_d;
      total_bytes_q <= total_bytes_d;
    end
  end

endmodule

// ===== sv/fdre_rec_buf.sv =====
module fdre_rec_buf import fdre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  rec_set_t  rec_set_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  rec_t [MAX_RECS-1:0]  recs_q;
  logic [REC_CNT_W-1:0] rem_q, rem_d;
  logic [REC_PTR_W-1:0] ptr_q, ptr_d;
  logic                 out_fire;

  assign out_valid_o = (rem_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  // free when empty or the final record leaves this cycle
  assign free_o      = (rem_q == '0) || ((rem_q == REC_CNT_W'(1)) && out_ready_i);

  assign out_data_o.record_type  = recs_q[ptr_q].rtype;
  assign out_data_o.record_value = recs_q[ptr_q].value;
  assign out_data_o.last_of_step = (rem_q == REC_CNT_W'(1));

  // Drain pointer and remaining count
  always_comb begin
    rem_d = rem_q;
    ptr_d = ptr_q;
    if (load_i) begin
      rem_d = rec_set_i.n;
      ptr_d = '0;
    end else if (out_fire) begin
      rem_d = rem_q - REC_CNT_W'(1);
      ptr_d = ptr_q + REC_PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      ptr_q <= '0;
    end else begin
      rem_q <= rem_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      recs_q <= rec_set_i.recs;
    end
  end

endmodule

// ===== sv/frame_delta_run_encoder.sv =====
// A beat is registered with its reference read, then compared; its records are buffered.
// One input beat per cycle unless the compare stage waits for a free record buffer.
// The reference store has one read and one write port; a same-entry overlap is bypassed.
// Reset clears word index, run state and all valid flags, and sets frame length 2073600.
// Reference store not cleared; user must prime each entry before compare; not enforced.
module frame_delta_run_encoder import fdre_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [FW_W-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_beat_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_beat_t       out_data_o
);

`include "frame_delta_run_encoder_defines.svh"

  logic [FW_W-1:0]   frame_words_q;
  logic [FW_W-1:0]   fw_eff;
  logic [IDX_W-1:0]  word_index_q, word_index_d;
  logic [IDX_W:0]    idx_p1;
  logic              s0_last;
  logic              in_fire;
  item_t             item_q, item_d;
  logic [WORD_W-1:0] ref_word;
  rec_set_t          rec_set;
  logic              ref_wr_en;
  logic              need_buf;
  logic              buf_free;
  logic              s1_fire;

  // Config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_words_q <= FRAME_WORDS_RST;
    end else if (cfg_valid_i) begin
      frame_words_q <= cfg_data_i;
    end
  end

  // Effective frame length, clamped to between one word and the store size
  always_comb begin
    if (frame_words_q == '0) begin
      fw_eff = FRAME_WORDS_MIN;
    end else if (frame_words_q > FRAME_WORDS_MAX) begin
      fw_eff = FRAME_WORDS_MAX;
    end else begin
      fw_eff = frame_words_q;
    end
  end

  // Index stage: last-word detect and index advance
  assign in_fire      = in_valid_i && in_ready_o;
  assign idx_p1       = {1'b0, word_index_q} + (IDX_W+1)'(1);
  assign s0_last      = (FW_W'(idx_p1) >= fw_eff);
  assign word_index_d = s0_last ? '0 : idx_p1[IDX_W-1:0];

  // Compare stage handshake
  assign need_buf   = (rec_set.n != '0);
  assign s1_fire    = item_q.valid && (!need_buf || buf_free);
  assign in_ready_o = !item_q.valid || s1_fire;

  always_comb begin
    item_d = item_q;
    if (in_fire) begin
      item_d.valid      = 1'b1;
      item_d.kind       = in_data_i.kind;
      item_d.pixel_word = in_data_i.pixel_word;
      item_d.idx        = word_index_q;
      item_d.last       = s0_last;
    end else if (s1_fire) begin
      item_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_index_q <= '0;
      item_q       <= '0;
    end else begin
      item_q <= item_d;
      if (in_fire) begin
        word_index_q <= word_index_d;
      end
    end
  end

  fdre_ref_ram u_ref_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (word_index_q),
    .wr_en_i   (ref_wr_en),
    .wr_addr_i (item_q.idx),
    .wr_data_i (item_q.pixel_word),
    .rd_data_o (ref_word)
  );

  fdre_run_ctrl u_run_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_q),
    .ref_word_i (ref_word),
    .advance_i  (s1_fire),
    .rec_set_o  (rec_set),
    .wr_en_o    (ref_wr_en)
  );

  fdre_rec_buf u_rec_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire && need_buf),
    .rec_set_i   (rec_set),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Checks
  `FDRE_ASSERT_SAME(a_total_is_last, out_valid_o && (out_data_o.record_type == REC_TOTAL), out_data_o.last_of_step, "frame total not last record of its beat")
  `FDRE_ASSERT_SAME(a_start_aligned, out_valid_o && (out_data_o.record_type == REC_START), out_data_o.record_value[1:0] == 2'b00, "run start offset not word aligned")
  `FDRE_ASSERT_NEXT(a_index_wraps, in_fire && s0_last, word_index_q == '0, "word index did not wrap after last word")
  `FDRE_ASSERT_SAME(a_prime_silent, s1_fire && (item_q.kind == KIND_PRIME), !need_buf && ref_wr_en, "prime beat produced records or skipped write")

endmodule
